### rtl/bch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_pkg
// Shared types, constants and helper functions of the bus command handler.
// ----------------------------------------------------------------------------
package bch_pkg;

    localparam int STORE_ENTRIES = 33;
    localparam int SCENE_COUNT   = 17;
    localparam int STORE_AW      = $clog2(STORE_ENTRIES);
    localparam int STORE_SLOTS   = 1 << STORE_AW;
    localparam int QDEPTH        = 2;
    localparam int QAW           = $clog2(QDEPTH);
    localparam int CFG_IW        = 2;

    localparam logic [7:0] BROADCAST_ADDR = 8'hff;
    localparam logic [7:0] GROUP_FIRST    = 8'd192;
    localparam logic [7:0] GROUP_LAST     = 8'd208;
    localparam logic [7:0] SCENE_BASE     = 8'd9;

    // store entries that also live in flops
    localparam logic [STORE_AW-1:0] ENTRY_POWER_ON = STORE_AW'(0);
    localparam logic [STORE_AW-1:0] ENTRY_MIN      = STORE_AW'(2);
    localparam logic [STORE_AW-1:0] ENTRY_MAX      = STORE_AW'(3);
    localparam logic [STORE_AW-1:0] ENTRY_SHORT    = STORE_AW'(6);
    localparam logic [STORE_AW-1:0] ENTRY_GROUP_LO = STORE_AW'(7);
    localparam logic [STORE_AW-1:0] ENTRY_GROUP_HI = STORE_AW'(8);
    localparam logic [STORE_AW-1:0] ENTRY_ZONE     = STORE_AW'(32);

    localparam logic [7:0] CMD_GOTO_LEVEL     = 8'd100;
    localparam logic [7:0] CMD_RECALL         = 8'd234;
    localparam logic [7:0] CMD_STORE_SCENE    = 8'd231;
    localparam logic [7:0] CMD_GROUP          = 8'h09;
    localparam logic [7:0] CMD_DTR_WRITE      = 8'h23;
    localparam logic [7:0] CMD_DTR_COMMIT     = 8'h24;
    localparam logic [7:0] CMD_QUERY_DTR      = 8'h25;
    localparam logic [7:0] CMD_DTR_LOAD       = 8'h26;
    localparam logic [7:0] CMD_QUERY_POWER_ON = 8'h27;
    localparam logic [7:0] CMD_QUERY_KIND     = 8'h31;

    localparam logic [CFG_IW-1:0] CFG_DEVICE_KIND    = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_SCENE_FALLBACK = CFG_IW'(1);

    localparam logic [7:0]  RST_LEVEL    = 8'd100;
    localparam logic [7:0]  RST_MIN      = 8'd0;
    localparam logic [7:0]  RST_MAX      = 8'd100;
    localparam logic [7:0]  RST_OWN      = 8'd128;
    localparam logic [7:0]  RST_ZONE     = 8'd219;
    localparam logic [15:0] RST_GROUP    = 16'd1;
    localparam logic [7:0]  RST_KIND     = 8'd2;
    localparam logic [7:0]  RST_FALLBACK = 8'd5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_GOTO,
        OP_RECALL,
        OP_STORE,
        OP_GROUP,
        OP_DTR_WR,
        OP_COMMIT,
        OP_Q_DTR,
        OP_LOAD,
        OP_Q_PWR,
        OP_Q_KIND
    } t_op;

    // decoded frame as it travels from front to back
    typedef struct packed {
        t_op                 op;
        logic                bcast;
        logic                grp_range;
        logic [3:0]          grp_bit;
        logic [7:0]          addr;
        logic [7:0]          dat;
        logic                in_range;
        logic [STORE_AW-1:0] mem_addr;
    } t_cmd;

    typedef struct packed {
        logic       accepted;
        logic       level_updated;
        logic [7:0] level;
        logic [2:0] speed_code;
        logic       reply_valid;
        logic [7:0] reply_address;
        logic [7:0] reply_data;
    } t_result;

    // factory image of the settings store
    function automatic logic [7:0] factory_value(input logic [STORE_AW-1:0] idx);
        unique case (idx)
            STORE_AW'(0):  return 8'd100;
            STORE_AW'(1):  return 8'd50;
            STORE_AW'(2):  return 8'd0;
            STORE_AW'(3):  return 8'd100;
            STORE_AW'(4):  return 8'd5;
            STORE_AW'(5):  return 8'd6;
            STORE_AW'(6):  return 8'd128;
            STORE_AW'(7):  return 8'd1;
            STORE_AW'(8):  return 8'd0;
            STORE_AW'(9):  return 8'd6;
            STORE_AW'(10): return 8'd7;
            STORE_AW'(11): return 8'd8;
            ENTRY_ZONE:    return 8'd219;
            default:       return 8'd255;
        endcase
    endfunction

    function automatic logic [2:0] speed_of(input logic [7:0] lv);
        priority if (lv <= 8'd10)  return 3'd0;
        else if (lv <= 8'd20)      return 3'd1;
        else if (lv <= 8'd30)      return 3'd2;
        else if (lv <= 8'd50)      return 3'd3;
        else if (lv <= 8'd70)      return 3'd4;
        else if (lv <= 8'd90)      return 3'd5;
        else if (lv <= 8'd100)     return 3'd6;
        else                       return 3'd0;
    endfunction

endpackage

### rtl/bch_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### rtl/bch_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_front
// Accepts frames, decodes the command and address class, and queues them.
// ----------------------------------------------------------------------------
module bch_front
    import bch_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_address,
    input  logic [7:0] i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    t_cmd           dec;
    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic [8:0]     scene_sum;
    logic           scene_ok, loc_ok, is_scene, wr;

    assign scene_sum = {1'b0, i_data_byte} + {1'b0, SCENE_BASE};
    assign scene_ok  = (i_data_byte < 8'(SCENE_COUNT)) && (scene_sum < 9'(STORE_ENTRIES));
    assign loc_ok    = i_data_byte < 8'(STORE_ENTRIES);

    always_comb begin
        dec = '0;
        unique case (i_func)
            CMD_GOTO_LEVEL:     dec.op = OP_GOTO;
            CMD_RECALL:         dec.op = OP_RECALL;
            CMD_STORE_SCENE:    dec.op = OP_STORE;
            CMD_GROUP:          dec.op = OP_GROUP;
            CMD_DTR_WRITE:      dec.op = OP_DTR_WR;
            CMD_DTR_COMMIT:     dec.op = OP_COMMIT;
            CMD_QUERY_DTR:      dec.op = OP_Q_DTR;
            CMD_DTR_LOAD:       dec.op = OP_LOAD;
            CMD_QUERY_POWER_ON: dec.op = OP_Q_PWR;
            CMD_QUERY_KIND:     dec.op = OP_Q_KIND;
            default:            dec.op = OP_NONE;
        endcase
        dec.bcast     = i_address == BROADCAST_ADDR;
        dec.grp_range = (i_address >= GROUP_FIRST) && (i_address <= GROUP_LAST);
        dec.grp_bit   = i_address[3:0];
        dec.addr      = i_address;
        dec.dat       = i_data_byte;
        // scene commands address the scene area, the others the raw location
        dec.in_range  = is_scene ? scene_ok : loc_ok;
        dec.mem_addr  = is_scene ? scene_sum[STORE_AW-1:0] : i_data_byte[STORE_AW-1:0];
    end

    assign is_scene = (i_func == CMD_RECALL) || (i_func == CMD_STORE_SCENE);

    assign o_full      = r_cnt == (QAW+1)'(QDEPTH);
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rp];
    assign wr          = i_push && !o_full;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) begin
            n_wp = (r_wp == QAW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rp = (r_rp == QAW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        if (wr && !i_cmd_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!wr && i_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

### rtl/bch_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_exec
// Back end: address match, command execution against the settings store,
// and the result register.
// ----------------------------------------------------------------------------
module bch_exec
    import bch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output t_result           o_res
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic                   r_rd_vld, n_rd_vld;
    logic [STORE_SLOTS-1:0] r_valid, n_valid;
    logic [7:0]             r_level, n_level, r_min, n_min, r_max, n_max;
    logic [7:0]             r_own, n_own, r_zone, n_zone;
    logic [15:0]            r_group, n_group;
    logic [7:0]             r_dtr, n_dtr;
    logic                   r_dtr_rdy, n_dtr_rdy;
    logic [7:0]             r_kind, n_kind, r_fallback, n_fallback;
    logic [7:0]             r_st_pwr, n_st_pwr, r_st_min, n_st_min, r_st_max, n_st_max;
    logic [7:0]             r_st_short, n_st_short, r_st_glo, n_st_glo;
    logic [7:0]             r_st_ghi, n_st_ghi, r_st_zone, n_st_zone;
    logic                   r_out_valid, n_out_valid;
    t_result                r_res, n_res;

    logic                   take, match;
    logic [7:0]             ram_q, rd_data, x_level, x_rdata, wr_data;
    logic                   x_updated, x_reply, x_reload, wr_en, ram_we;
    logic [15:0]            grp_new;

    assign take      = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = take;
    assign o_empty   = !r_out_valid;
    assign o_res     = r_res;

    bch_ram #(
        .WIDTH (8),
        .DEPTH (STORE_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmd.mem_addr),
        .i_wdata (wr_data),
        .i_re    (take),
        .i_raddr (i_cmd.mem_addr),
        .o_rdata (ram_q)
    );

    // entries kept in flops win over the ram; unwritten ram entries read factory
    always_comb begin
        unique case (r_cmd.mem_addr)
            ENTRY_POWER_ON: rd_data = r_st_pwr;
            ENTRY_MIN:      rd_data = r_st_min;
            ENTRY_MAX:      rd_data = r_st_max;
            ENTRY_SHORT:    rd_data = r_st_short;
            ENTRY_GROUP_LO: rd_data = r_st_glo;
            ENTRY_GROUP_HI: rd_data = r_st_ghi;
            ENTRY_ZONE:     rd_data = r_st_zone;
            default:        rd_data = r_rd_vld ? ram_q : factory_value(r_cmd.mem_addr);
        endcase
    end

    assign match = r_cmd.bcast || (r_cmd.addr == r_own) || (r_cmd.addr == r_zone)
                   || (r_cmd.grp_range && r_group[r_cmd.grp_bit]);

    assign grp_new = ({r_st_ghi, r_st_glo} & ~(16'd1 << r_cmd.dat[3:0]))
                     | ({15'd0, r_cmd.dat[4]} << r_cmd.dat[3:0]);

    always_comb begin
        n_state     = r_state;
        n_cmd       = take ? i_cmd : r_cmd;
        n_rd_vld    = take ? (i_cmd.in_range && r_valid[i_cmd.mem_addr]) : r_rd_vld;
        n_valid     = r_valid;
        n_level     = r_level;
        n_min       = r_min;
        n_max       = r_max;
        n_own       = r_own;
        n_zone      = r_zone;
        n_group     = r_group;
        n_dtr       = r_dtr;
        n_dtr_rdy   = r_dtr_rdy;
        n_kind      = r_kind;
        n_fallback  = r_fallback;
        n_st_pwr    = r_st_pwr;
        n_st_min    = r_st_min;
        n_st_max    = r_st_max;
        n_st_short  = r_st_short;
        n_st_glo    = r_st_glo;
        n_st_ghi    = r_st_ghi;
        n_st_zone   = r_st_zone;
        n_out_valid = r_out_valid && !i_pop;
        n_res       = r_res;
        x_level     = r_level;
        x_updated   = 1'b0;
        x_reply     = 1'b0;
        x_rdata     = 8'd0;
        x_reload    = 1'b0;
        wr_en       = 1'b0;
        wr_data     = r_level;
        ram_we      = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_KIND:    n_kind     = i_cfg_data;
                CFG_SCENE_FALLBACK: n_fallback = i_cfg_data;
                default:            ;
            endcase
        end

        if (take) begin
            n_state = S_EXEC;
        end

        if (r_state == S_EXEC) begin
            n_state = S_IDLE;
            if (match) begin
                unique case (r_cmd.op)
                    OP_GOTO: begin
                        if (r_cmd.dat > r_max) begin
                            x_level = r_max;
                        end else if (r_cmd.dat < r_min) begin
                            x_level = r_min;
                        end else begin
                            x_level = r_cmd.dat;
                        end
                        x_updated = 1'b1;
                    end
                    OP_RECALL: begin
                        if (r_cmd.in_range) begin
                            x_level = (rd_data <= r_min) ? r_fallback : rd_data;
                        end
                        x_updated = 1'b1;
                    end
                    OP_STORE: begin
                        wr_en = r_cmd.in_range;
                    end
                    OP_GROUP: begin
                        n_group  = grp_new;
                        n_st_glo = grp_new[7:0];
                        n_st_ghi = grp_new[15:8];
                    end
                    OP_DTR_WR: begin
                        n_dtr     = r_cmd.dat;
                        n_dtr_rdy = 1'b1;
                    end
                    OP_COMMIT: begin
                        if (r_dtr_rdy && r_cmd.in_range) begin
                            n_dtr_rdy = 1'b0;
                            wr_en     = 1'b1;
                            wr_data   = r_dtr;
                        end
                        x_reload = 1'b1;
                    end
                    OP_Q_DTR: begin
                        x_reply = 1'b1;
                        x_rdata = r_dtr;
                    end
                    OP_LOAD: begin
                        if (r_cmd.in_range) begin
                            n_dtr = rd_data;
                        end
                    end
                    OP_Q_PWR: begin
                        x_reply = 1'b1;
                        x_rdata = r_st_pwr;
                    end
                    OP_Q_KIND: begin
                        x_reply = 1'b1;
                        x_rdata = r_kind;
                    end
                    OP_NONE: ;
                    default: ;
                endcase
            end

            if (wr_en) begin
                unique case (r_cmd.mem_addr)
                    ENTRY_POWER_ON: n_st_pwr   = wr_data;
                    ENTRY_MIN:      n_st_min   = wr_data;
                    ENTRY_MAX:      n_st_max   = wr_data;
                    ENTRY_SHORT:    n_st_short = wr_data;
                    ENTRY_GROUP_LO: n_st_glo   = wr_data;
                    ENTRY_GROUP_HI: n_st_ghi   = wr_data;
                    ENTRY_ZONE:     n_st_zone  = wr_data;
                    default: begin
                        ram_we                  = 1'b1;
                        n_valid[r_cmd.mem_addr] = 1'b1;
                    end
                endcase
            end

            // reload sees the value just committed
            if (x_reload) begin
                n_group = {n_st_ghi, n_st_glo};
                n_min   = n_st_min;
                n_max   = n_st_max;
                n_own   = n_st_short;
                n_zone  = n_st_zone;
            end

            // power-on level save after every matched, recognized command
            if (match && (r_cmd.op != OP_NONE)) begin
                n_st_pwr = x_level;
            end

            n_level                 = x_level;
            n_out_valid             = 1'b1;
            n_res.accepted          = match;
            n_res.level_updated     = x_updated;
            n_res.level             = x_level;
            n_res.speed_code        = speed_of(x_level);
            n_res.reply_valid       = x_reply;
            n_res.reply_address     = x_reply ? n_own : 8'd0;
            n_res.reply_data        = x_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_rd_vld <= n_rd_vld;
        r_res    <= n_res;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_level     <= RST_LEVEL;
            r_min       <= RST_MIN;
            r_max       <= RST_MAX;
            r_own       <= RST_OWN;
            r_zone      <= RST_ZONE;
            r_group     <= RST_GROUP;
            r_dtr       <= 8'd0;
            r_dtr_rdy   <= 1'b0;
            r_kind      <= RST_KIND;
            r_fallback  <= RST_FALLBACK;
            r_st_pwr    <= factory_value(ENTRY_POWER_ON);
            r_st_min    <= factory_value(ENTRY_MIN);
            r_st_max    <= factory_value(ENTRY_MAX);
            r_st_short  <= factory_value(ENTRY_SHORT);
            r_st_glo    <= factory_value(ENTRY_GROUP_LO);
            r_st_ghi    <= factory_value(ENTRY_GROUP_HI);
            r_st_zone   <= factory_value(ENTRY_ZONE);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_level     <= n_level;
            r_min       <= n_min;
            r_max       <= n_max;
            r_own       <= n_own;
            r_zone      <= n_zone;
            r_group     <= n_group;
            r_dtr       <= n_dtr;
            r_dtr_rdy   <= n_dtr_rdy;
            r_kind      <= n_kind;
            r_fallback  <= n_fallback;
            r_st_pwr    <= n_st_pwr;
            r_st_min    <= n_st_min;
            r_st_max    <= n_st_max;
            r_st_short  <= n_st_short;
            r_st_glo    <= n_st_glo;
            r_st_ghi    <= n_st_ghi;
            r_st_zone   <= n_st_zone;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/bus_command_handler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_command_handler
// Command handler for one control gear on a two-wire lighting bus.
//
//   channel   handshake                 payload
//   frame in  push / full               i_address, i_func, i_data_byte
//   result    empty / pop               o_accepted .. o_reply_data
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A frame waits at the head of the front queue until the back end takes it and
// issues its store read, then executes in the next cycle; a new frame is taken
// only once the last has executed. Queue entry, command and result are registered.
// The front queue holds 2 frames and keeps accepting while a result waits;
// the back end stalls while its result register is full and not popped.
// Synchronous reset restores the factory settings at once; no clearing pass.
// ----------------------------------------------------------------------------
module bus_command_handler
    import bch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_address,
    input  logic [7:0]        i_func,
    input  logic [7:0]        i_data_byte,
    output logic              empty,
    input  logic              pop,
    output logic              o_accepted,
    output logic              o_level_updated,
    output logic [7:0]        o_level,
    output logic [2:0]        o_speed_code,
    output logic              o_reply_valid,
    output logic [7:0]        o_reply_address,
    output logic [7:0]        o_reply_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    t_cmd    cmd;
    logic    cmd_valid, cmd_pop, res_pop;
    t_result res;

    assign o_cfg_ready = 1'b1;
    assign res_pop     = pop && !empty;

    bch_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_address   (i_address),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    bch_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (res_pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_accepted      = res.accepted;
    assign o_level_updated = res.level_updated;
    assign o_level         = res.level;
    assign o_speed_code    = res.speed_code;
    assign o_reply_valid   = res.reply_valid;
    assign o_reply_address = res.reply_address;
    assign o_reply_data    = res.reply_data;

    // a reply or a level update only comes from a matched frame
    a_reply_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_reply_valid || o_level_updated) |-> o_accepted)
        else $error("reply or level update on an unmatched frame");

    a_no_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_reply_valid |-> (o_reply_data == 8'd0) && (o_reply_address == 8'd0))
        else $error("reply fields not cleared without a reply");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_speed_code <= 3'd6)
        else $error("speed code out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !full && empty)
        else $error("queues not empty after reset");

endmodule
